// ===== design/tztl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the time-zone transition lookup.
// Holds the request codes, sequencer states, table entry layout and shared constants.
package tztl_pkg;

   localparam int unsigned MAX_TRANSITIONS_DEF = 256;

   localparam int unsigned ACTION_W    = 2;
   localparam int unsigned START_S_W   = 55;
   localparam int unsigned START_MS_W  = 64;
   localparam int unsigned OFFSET_W    = 18;
   localparam int unsigned OFFSET_MS_W = 28;
   localparam int unsigned ABBREV_W    = 8;
   localparam int unsigned TIME_W      = 64;
   localparam int unsigned USED_W      = 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_CALC,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic signed [START_MS_W-1:0] start_ms;
      logic signed [OFFSET_W-1:0]   offset_s;
      logic [ABBREV_W-1:0]          abbrev;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic append;
   } tbl_cmd_type;

endpackage

// ===== design/tztl_store.sv =====
`timescale 1ns / 1ps
// Transition table memory with its fill count and the seconds-to-milliseconds scaling on append.
// Depends on tztl_pkg.
module tztl_store #(
   parameter int unsigned MAX_TRANSITIONS = tztl_pkg::MAX_TRANSITIONS_DEF,
   parameter int unsigned CW = $clog2(MAX_TRANSITIONS + 1),
   parameter int unsigned IW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tztl_pkg::tbl_cmd_type                 cmd,
   input  logic signed [tztl_pkg::START_S_W-1:0] wr_start_seconds,
   input  logic signed [tztl_pkg::OFFSET_W-1:0]  wr_offset_seconds,
   input  logic [tztl_pkg::ABBREV_W-1:0]         wr_abbrev_index,
   input  logic [IW-1:0]                         rd_addr,
   output tztl_pkg::entry_type                   rd_data,
   output logic [CW-1:0]                         count
);
   import tztl_pkg::*;

   localparam int unsigned PROD_W = START_MS_W + 2;

   entry_type               mem [MAX_TRANSITIONS];
   entry_type               rd_data_ff;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic                    not_full;
   logic signed [PROD_W-1:0] sec_ext;
   logic signed [PROD_W-1:0] ms_full;
   entry_type               wr_entry;

   assign not_full = (count_ff < CW'(MAX_TRANSITIONS));

   // 1000 = 1024 - 32 + 8.
   always_comb begin
      sec_ext = PROD_W'(wr_start_seconds);
      ms_full = (sec_ext <<< 10) - (sec_ext <<< 5) + (sec_ext <<< 3);
      wr_entry.offset_s = wr_offset_seconds;
      wr_entry.abbrev   = wr_abbrev_index;
      if ((ms_full[PROD_W-1:START_MS_W-1] == '0) || (ms_full[PROD_W-1:START_MS_W-1] == '1)) begin
         wr_entry.start_ms = ms_full[START_MS_W-1:0];
      end else if (ms_full[PROD_W-1]) begin
         wr_entry.start_ms = {1'b1, {(START_MS_W-1){1'b0}}};
      end else begin
         wr_entry.start_ms = {1'b0, {(START_MS_W-1){1'b1}}};
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append && not_full) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && not_full) begin
         mem[count_ff[IW-1:0]] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign count   = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TRANSITIONS))
      else $error("Entry count is above the table depth.");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0))
      else $error("Clear did not empty the table.");

   a_full_drops: assert property (@(posedge clock) disable iff (reset)
      (cmd.append && !not_full) |=> $stable(count_ff))
      else $error("An append to a full table changed the count.");

endmodule

// ===== design/tztl_seq.sv =====
`timescale 1ns / 1ps
// Sequencer for the lookup: request handshake, table scan with one shared comparator,
// offset scaling, saturating add and the result register. Depends on tztl_pkg.
module tztl_seq #(
   parameter int unsigned MAX_TRANSITIONS = tztl_pkg::MAX_TRANSITIONS_DEF,
   parameter int unsigned CW = $clog2(MAX_TRANSITIONS + 1),
   parameter int unsigned IW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tztl_pkg::ACTION_W-1:0]      req_action,
   input  logic signed [tztl_pkg::TIME_W-1:0] req_utc_ms,
   output tztl_pkg::tbl_cmd_type              cmd,
   output logic [IW-1:0]                      rd_addr,
   input  tztl_pkg::entry_type                rd_data,
   input  logic [CW-1:0]                      count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tztl_pkg::TIME_W-1:0] rsp_local_ms,
   output logic [tztl_pkg::ABBREV_W-1:0]      rsp_type_abbrev,
   output logic [tztl_pkg::USED_W-1:0]        rsp_entry_used,
   output logic                               rsp_table_empty
);
   import tztl_pkg::*;

   localparam int unsigned MULT_W = OFFSET_MS_W + 1;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 iss_ff, iss_in;
   logic                          cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]                 cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]                 line_ff, line_in;
   logic                          empty_ff, empty_in;
   logic signed [TIME_W-1:0]      utc_ff, utc_in;
   logic signed [OFFSET_MS_W-1:0] ofs_ms_ff, ofs_ms_in;
   logic [ABBREV_W-1:0]           abbrev_ff, abbrev_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [TIME_W-1:0]      local_ff, local_in;
   logic [ABBREV_W-1:0]           rsp_abbrev_ff, rsp_abbrev_in;
   logic [USED_W-1:0]             used_ff, used_in;
   logic                          rsp_empty_ff, rsp_empty_in;

   logic                          accept;
   action_type                    action;
   logic                          issue;
   logic                          hit;
   logic                          scan_end;
   logic                          rsp_load;
   logic [CW-1:0]                 count_m1;
   logic signed [MULT_W-1:0]      mult;
   logic signed [TIME_W:0]        sum;
   logic [IW+USED_W-1:0]          line_ext;

   assign action   = action_type'(req_action);
   assign accept   = req_valid && req_ready;
   assign issue    = (state_ff == ST_SCAN) && (iss_ff < count);
   assign hit      = cmp_vld_ff && ($signed(utc_ff) < $signed(rd_data.start_ms));
   assign scan_end = !cmp_vld_ff && (iss_ff == count);
   assign rsp_load = (state_ff == ST_SUM) && (!rsp_valid_ff || rsp_ready);
   assign count_m1 = count - CW'(1);
   assign line_ext = {{USED_W{1'b0}}, line_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (action == ACT_QUERY)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_FETCH;
            end else if (scan_end) begin
               state_in = (count == '0) ? ST_SUM : ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_CALC;
         ST_CALC:  state_in = ST_SUM;
         ST_SUM: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd.clear  = accept && (action == ACT_CLEAR);
      cmd.append = accept && (action == ACT_APPEND);
      case (state_ff)
         ST_FETCH: rd_addr = line_ff;
         default:  rd_addr = iss_ff[IW-1:0];
      endcase
   end

   always_comb begin
      iss_in     = iss_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      line_in    = line_ff;
      empty_in   = empty_ff;
      utc_in     = utc_ff;
      ofs_ms_in  = ofs_ms_ff;
      abbrev_in  = abbrev_ff;
      mult       = MULT_W'(rd_data.offset_s) * MULT_W'(1000);
      if (state_ff == ST_IDLE) begin
         iss_in   = '0;
         empty_in = 1'b0;
         if (accept) begin
            utc_in = req_utc_ms;
         end
      end
      if (issue) begin
         iss_in     = iss_ff + CW'(1);
         cmp_vld_in = 1'b1;
         cmp_idx_in = iss_ff[IW-1:0];
      end
      if (state_ff == ST_SCAN) begin
         if (hit) begin
            line_in = (cmp_idx_ff == '0) ? '0 : cmp_idx_ff - IW'(1);
         end else if (scan_end) begin
            line_in  = count_m1[IW-1:0];
            empty_in = (count == '0);
         end
      end
      if (state_ff == ST_CALC) begin
         ofs_ms_in = mult[OFFSET_MS_W-1:0];
         abbrev_in = rd_data.abbrev;
      end
   end

   always_comb begin
      sum           = {utc_ff[TIME_W-1], utc_ff} + (TIME_W+1)'(ofs_ms_ff);
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      local_in      = local_ff;
      rsp_abbrev_in = rsp_abbrev_ff;
      used_in       = used_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (empty_ff) begin
            local_in      = utc_ff;
            rsp_abbrev_in = '0;
            used_in       = '0;
            rsp_empty_in  = 1'b1;
         end else begin
            if (sum[TIME_W] == sum[TIME_W-1]) begin
               local_in = sum[TIME_W-1:0];
            end else if (sum[TIME_W]) begin
               local_in = {1'b1, {(TIME_W-1){1'b0}}};
            end else begin
               local_in = {1'b0, {(TIME_W-1){1'b1}}};
            end
            rsp_abbrev_in = abbrev_ff;
            used_in       = line_ext[USED_W-1:0];
            rsp_empty_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         iss_ff       <= '0;
         empty_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         iss_ff       <= iss_in;
         empty_ff     <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff    <= cmp_idx_in;
      line_ff       <= line_in;
      utc_ff        <= utc_in;
      ofs_ms_ff     <= ofs_ms_in;
      abbrev_ff     <= abbrev_in;
      local_ff      <= local_in;
      rsp_abbrev_ff <= rsp_abbrev_in;
      used_ff       <= used_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_local_ms    = local_ff;
   assign rsp_type_abbrev = rsp_abbrev_ff;
   assign rsp_entry_used  = used_ff;
   assign rsp_table_empty = rsp_empty_ff;

   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SUM))
      else $error("A response appeared without a completed lookup.");

   a_fetch_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (CW'(line_ff) < count))
      else $error("Selected entry lies beyond the filled part of the table.");

   a_cmp_in_table: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (CW'(cmp_idx_ff) < count))
      else $error("Compared entry lies beyond the filled part of the table.");

   a_count_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> $stable(count))
      else $error("The table changed during a lookup.");

endmodule

// ===== design/timezone_transition_lookup.sv =====
`timescale 1ns / 1ps
// Time-zone transition table with UTC-to-local lookup; top level over tztl_store and tztl_seq.
// Clear and append requests are accepted back to back. A query scans the entries in order
// through the single comparator and memory read port up to the first that starts after the
// time, or to the end, then reads the entry before it (or entry 0), scales its offset and adds
// it; an empty table returns the time as is. A new request is taken once the response turns valid.
// Synchronous reset empties the table and idles the sequencer; the memory itself is not cleared.
module timezone_transition_lookup #(
   parameter int unsigned MAX_TRANSITIONS = tztl_pkg::MAX_TRANSITIONS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [tztl_pkg::ACTION_W-1:0]         req_action,
   input  logic signed [tztl_pkg::START_S_W-1:0] req_start_seconds,
   input  logic signed [tztl_pkg::OFFSET_W-1:0]  req_offset_seconds,
   input  logic [tztl_pkg::ABBREV_W-1:0]         req_abbrev_index,
   input  logic signed [tztl_pkg::TIME_W-1:0]    req_utc_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tztl_pkg::TIME_W-1:0]    rsp_local_ms,
   output logic [tztl_pkg::ABBREV_W-1:0]         rsp_type_abbrev,
   output logic [tztl_pkg::USED_W-1:0]           rsp_entry_used,
   output logic                                  rsp_table_empty
);
   import tztl_pkg::*;

   localparam int unsigned CW = $clog2(MAX_TRANSITIONS + 1);
   localparam int unsigned IW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;

   tbl_cmd_type   cmd;
   logic [IW-1:0] rd_addr;
   entry_type     rd_data;
   logic [CW-1:0] count;

   tztl_store #(
      .MAX_TRANSITIONS (MAX_TRANSITIONS),
      .CW              (CW),
      .IW              (IW)
   ) u_store (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .wr_start_seconds  (req_start_seconds),
      .wr_offset_seconds (req_offset_seconds),
      .wr_abbrev_index   (req_abbrev_index),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .count             (count)
   );

   tztl_seq #(
      .MAX_TRANSITIONS (MAX_TRANSITIONS),
      .CW              (CW),
      .IW              (IW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_utc_ms      (req_utc_ms),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .count           (count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_local_ms    (rsp_local_ms),
      .rsp_type_abbrev (rsp_type_abbrev),
      .rsp_entry_used  (rsp_entry_used),
      .rsp_table_empty (rsp_table_empty)
   );

endmodule

// ===== dv/tb_timezone_transition_lookup.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for timezone_transition_lookup: clear, append and query requests
// with a predicted transition table and a response check. Depends on tztl_pkg and the RTL.
module tb_timezone_transition_lookup;
   import tztl_pkg::*;

   localparam int    TABLE_DEPTH = MAX_TRANSITIONS_DEF;
   localparam int    N_RANDOM    = 1320;
   localparam int    END_WAIT    = 300;
   localparam int    CYCLE_LIMIT = 3_000_000;
   localparam int    PRINT_LIMIT = 50;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam longint TIME_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint TIME_MIN   = 64'sh8000_0000_0000_0000;
   localparam longint SEC_MS_MAX = 64'sd9223372036854775;
   localparam logic signed [START_S_W-1:0] START_S_MAX = {1'b0, {(START_S_W-1){1'b1}}};
   localparam logic signed [START_S_W-1:0] START_S_MIN = {1'b1, {(START_S_W-1){1'b0}}};
   localparam logic signed [OFFSET_W-1:0]  OFFSET_MAX  = {1'b0, {(OFFSET_W-1){1'b1}}};
   localparam logic signed [OFFSET_W-1:0]  OFFSET_MIN  = {1'b1, {(OFFSET_W-1){1'b0}}};

   typedef struct {
      logic signed [TIME_W-1:0] local_ms;
      logic [ABBREV_W-1:0]      abbrev;
      logic [USED_W-1:0]        used;
      logic                     empty;
   } conversion_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [ACTION_W-1:0]          req_action;
   logic signed [START_S_W-1:0]  req_start_seconds;
   logic signed [OFFSET_W-1:0]   req_offset_seconds;
   logic [ABBREV_W-1:0]          req_abbrev_index;
   logic signed [TIME_W-1:0]     req_utc_ms;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [TIME_W-1:0]     rsp_local_ms;
   logic [ABBREV_W-1:0]          rsp_type_abbrev;
   logic [USED_W-1:0]            rsp_entry_used;
   logic                         rsp_table_empty;

   longint                       tbl_start_ms [TABLE_DEPTH];
   logic signed [OFFSET_W-1:0]   tbl_offset_s [TABLE_DEPTH];
   logic [ABBREV_W-1:0]          tbl_abbrev [TABLE_DEPTH];
   int                           tbl_count;
   conversion_type               conversions_due[$];

   int error_count;
   int n_clear, n_append, n_dropped, n_query, n_empty_query, n_saturated, n_ignored;
   int n_checked;
   int cycle_count;
   int tx_burst_left;
   bit tx_idle_en;
   bit rx_stall_en;
   int rsp_hold_cycles;
   int rx_hold_left;
   int rx_stall_left;

   timezone_transition_lookup u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_start_seconds  (req_start_seconds),
      .req_offset_seconds (req_offset_seconds),
      .req_abbrev_index   (req_abbrev_index),
      .req_utc_ms         (req_utc_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_local_ms       (rsp_local_ms),
      .rsp_type_abbrev    (rsp_type_abbrev),
      .rsp_entry_used     (rsp_entry_used),
      .rsp_table_empty    (rsp_table_empty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic signed [OFFSET_W-1:0] pick_offset();
      if ($urandom_range(0, 7) == 0) begin
         return OFFSET_W'(rand64());
      end
      return OFFSET_W'($urandom_range(0, 172800) - 86400);
   endfunction

   function automatic longint seconds_to_ms(input logic signed [START_S_W-1:0] secs);
      longint s;
      s = secs;
      if (s > SEC_MS_MAX) begin
         return TIME_MAX;
      end
      if (s < -SEC_MS_MAX) begin
         return TIME_MIN;
      end
      return s * 1000;
   endfunction

   function automatic conversion_type convert_utc(input longint utc);
      conversion_type res;
      int          line;
      longint      off_ms;
      longint      sum;
      res.local_ms = utc;
      res.abbrev   = '0;
      res.used     = '0;
      res.empty    = 1'b1;
      if (tbl_count == 0) begin
         return res;
      end
      line = tbl_count - 1;
      for (int i = 0; i < tbl_count; i++) begin
         if (utc < tbl_start_ms[i]) begin
            line = (i == 0) ? 0 : i - 1;
            break;
         end
      end
      off_ms = longint'(tbl_offset_s[line]) * 1000;
      sum = utc + off_ms;
      if (off_ms > 0 && sum < utc) begin
         sum = TIME_MAX;
      end else if (off_ms < 0 && sum > utc) begin
         sum = TIME_MIN;
      end
      res.local_ms = sum;
      res.abbrev   = tbl_abbrev[line];
      res.used     = line[USED_W-1:0];
      res.empty    = 1'b0;
      return res;
   endfunction

   // Updates the predicted table for one accepted request and queues any conversion due.
   task automatic track_request(input logic [ACTION_W-1:0] act,
                                input logic signed [START_S_W-1:0] start_s,
                                input logic signed [OFFSET_W-1:0] off_s,
                                input logic [ABBREV_W-1:0] abbrev,
                                input logic signed [TIME_W-1:0] utc);
      conversion_type res;
      case (act)
         ACT_CLEAR: begin
            tbl_count = 0;
            n_clear++;
         end
         ACT_APPEND: begin
            n_append++;
            if (tbl_count < TABLE_DEPTH) begin
               tbl_start_ms[tbl_count] = seconds_to_ms(start_s);
               tbl_offset_s[tbl_count] = off_s;
               tbl_abbrev[tbl_count]   = abbrev;
               tbl_count++;
            end else begin
               n_dropped++;
            end
         end
         ACT_QUERY: begin
            res = convert_utc(utc);
            n_query++;
            if (res.empty) begin
               n_empty_query++;
            end else if (res.local_ms == TIME_MAX || res.local_ms == TIME_MIN) begin
               n_saturated++;
            end
            conversions_due = {conversions_due, res};
         end
         default: begin
            n_ignored++;
         end
      endcase
   endtask

   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic signed [START_S_W-1:0] start_s,
                               input logic signed [OFFSET_W-1:0] off_s,
                               input logic [ABBREV_W-1:0] abbrev,
                               input logic signed [TIME_W-1:0] utc);
      req_valid          <= 1'b1;
      req_action         <= act;
      req_start_seconds  <= start_s;
      req_offset_seconds <= off_s;
      req_abbrev_index   <= abbrev;
      req_utc_ms         <= utc;
      do @(posedge clock); while (!req_ready);
      track_request(act, start_s, off_s, abbrev, utc);
      if (tx_idle_en) begin
         if (tx_burst_left > 0) begin
            tx_burst_left--;
         end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            tx_burst_left = $urandom_range(0, 20);
         end
      end
   endtask

   // Fields that the action does not use carry random values.
   task automatic clear_table();
      send_request(ACT_CLEAR, START_S_W'(rand64()), OFFSET_W'(rand64()),
                   ABBREV_W'(rand64()), rand64());
   endtask

   task automatic append_entry(input logic signed [START_S_W-1:0] start_s,
                               input logic signed [OFFSET_W-1:0] off_s,
                               input logic [ABBREV_W-1:0] abbrev);
      send_request(ACT_APPEND, start_s, off_s, abbrev, rand64());
   endtask

   task automatic query_utc(input logic signed [TIME_W-1:0] utc);
      send_request(ACT_QUERY, START_S_W'(rand64()), OFFSET_W'(rand64()),
                   ABBREV_W'(rand64()), utc);
   endtask

   task automatic send_unused();
      send_request(ACT_UNUSED, START_S_W'(rand64()), OFFSET_W'(rand64()),
                   ABBREV_W'(rand64()), rand64());
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (conversions_due.size() != 0) @(posedge clock);
   endtask

   function automatic longint pick_query_utc();
      int     r;
      int     j;
      longint base;
      r = $urandom_range(0, 11);
      if (tbl_count == 0 || r == 0) begin
         return rand64();
      end
      if (r == 1) begin
         return ($urandom_range(0, 1) != 0) ? TIME_MAX : TIME_MIN;
      end
      j = $urandom_range(0, tbl_count - 1);
      base = tbl_start_ms[j];
      case (r)
         2, 3:    return base - 1;
         4, 5:    return base;
         6, 7:    return base + 1;
         default: return base + longint'($signed($urandom));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
      error_count++;
   endtask

   always @(posedge clock) begin : check_responses
      conversion_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (conversions_due.size() == 0) begin
            report_mismatch($sformatf("response with no query outstanding, local_ms %0d",
                                      rsp_local_ms));
         end else begin
            want = conversions_due.pop_front();
            n_checked++;
            if (rsp_local_ms !== want.local_ms) begin
               report_mismatch($sformatf("local_ms got %0d want %0d",
                                         rsp_local_ms, want.local_ms));
            end
            if (rsp_type_abbrev !== want.abbrev) begin
               report_mismatch($sformatf("type_abbrev got %0d want %0d",
                                         rsp_type_abbrev, want.abbrev));
            end
            if (rsp_entry_used !== want.used) begin
               report_mismatch($sformatf("entry_used got %0d want %0d",
                                         rsp_entry_used, want.used));
            end
            if (rsp_table_empty !== want.empty) begin
               report_mismatch($sformatf("table_empty got %0b want %0b",
                                         rsp_table_empty, want.empty));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rx_hold_left = rsp_hold_cycles;
         rsp_hold_cycles = 0;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_ready <= 1'b0;
      end else if (!rx_stall_en) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= (cycle_count % 7 != 3) && ($urandom_range(0, 5) != 0);
         if ($urandom_range(0, 31) == 0) begin
            rx_stall_left = $urandom_range(2, 20);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("tb_timezone_transition_lookup: done, errors");
         $finish;
      end
   end

   task automatic test_directed_edges();
      tx_idle_en = 1'b0;
      rx_stall_en = 1'b0;
      query_utc(rand64());
      send_unused();
      query_utc(TIME_MIN);
      append_entry(START_S_MIN, -18'sd86400, 8'd0);
      append_entry('0, 18'sd86400, 8'hFF);
      append_entry(START_S_MAX, OFFSET_MAX, 8'hA5);
      append_entry(START_S_W'(SEC_MS_MAX), OFFSET_MIN, 8'h5A);
      append_entry(START_S_W'(-SEC_MS_MAX), 18'sd0, 8'h01);
      query_utc(TIME_MIN);
      query_utc(-64'sd1);
      query_utc(64'sd0);
      query_utc(TIME_MAX - 1000);
      query_utc(TIME_MAX);
      query_utc(SEC_MS_MAX * 1000);
      send_unused();
      query_utc(64'sd0);
      clear_table();
      query_utc(TIME_MAX);
      append_entry(START_S_W'(64'sd100), 18'sd3600, 8'd7);
      query_utc(64'sd99999);
      query_utc(64'sd100000);
      wait_all_responses();
   endtask

   task automatic test_table_full();
      longint secs;
      tx_idle_en = 1'b1;
      rx_stall_en = 1'b1;
      clear_table();
      secs = -64'sd2000000000;
      for (int i = 0; i < TABLE_DEPTH + 6; i++) begin
         append_entry(START_S_W'(secs), pick_offset(), ABBREV_W'($urandom_range(0, 255)));
         secs += longint'($urandom_range(1, 20000000));
      end
      repeat (12) query_utc(pick_query_utc());
      query_utc(TIME_MAX);
      query_utc(TIME_MIN);
      wait_all_responses();
   endtask

   task automatic test_backpressure();
      tx_idle_en = 1'b0;
      rx_stall_en = 1'b0;
      clear_table();
      for (int i = 0; i < 6; i++) begin
         append_entry(START_S_W'(longint'(i) * 86400), pick_offset(),
                      ABBREV_W'($urandom_range(0, 255)));
      end
      rsp_hold_cycles = 400;
      repeat (14) query_utc(pick_query_utc());
      append_entry(START_S_W'(64'sd900000), pick_offset(), 8'd9);
      query_utc(64'sd900000000);
      wait_all_responses();
   endtask

   task automatic test_random_sequences();
      int     start_total;
      int     r;
      int     n;
      longint secs;
      start_total = n_clear + n_append + n_query;
      while (n_clear + n_append + n_query - start_total < N_RANDOM) begin
         tx_idle_en = ($urandom_range(0, 3) != 0);
         rx_stall_en = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 9);
         if (r < 7) begin
            clear_table();
            if ($urandom_range(0, 59) == 0) begin
               n = $urandom_range(200, TABLE_DEPTH + 10);
            end else if ($urandom_range(0, 19) == 0) begin
               n = $urandom_range(13, 64);
            end else begin
               n = $urandom_range(0, 12);
            end
            if ($urandom_range(0, 5) == 0) begin
               secs = longint'($signed(START_S_W'(rand64())));
            end else begin
               secs = longint'($signed($urandom)) * 4;
            end
            for (int i = 0; i < n; i++) begin
               append_entry(START_S_W'(secs), pick_offset(), ABBREV_W'($urandom_range(0, 255)));
               if ($urandom_range(0, 9) != 0) begin
                  secs += longint'($urandom_range(1, 50000000));
               end
            end
            repeat ($urandom_range(1, 6)) query_utc(pick_query_utc());
         end else if (r < 9) begin
            repeat ($urandom_range(1, 6)) begin
               send_request(ACTION_W'($urandom_range(0, 3)), START_S_W'(rand64()),
                            OFFSET_W'(rand64()), ABBREV_W'(rand64()), rand64());
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               append_entry(START_S_W'(rand64()), pick_offset(),
                            ABBREV_W'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(1, 3)) query_utc(pick_query_utc());
         end
         if ($urandom_range(0, 15) == 0) begin
            wait_all_responses();
         end
      end
      wait_all_responses();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_CLEAR;
      req_start_seconds = '0;
      req_offset_seconds = '0;
      req_abbrev_index = '0;
      req_utc_ms = '0;
      tbl_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_table_full();
      test_backpressure();
      test_random_sequences();
      wait_all_responses();
      repeat (END_WAIT) @(posedge clock);
      while (conversions_due.size() != 0) begin
         void'(conversions_due.pop_front());
         report_mismatch("query left without a response");
      end
      $display("Covered %0d queries (%0d on an empty table, %0d saturated), %0d appends",
               n_query, n_empty_query, n_saturated, n_append);
      $display("(%0d dropped when full), %0d clears, %0d ignored; %0d responses checked.",
               n_dropped, n_clear, n_ignored, n_checked);
      if (error_count == 0) begin
         $display("tb_timezone_transition_lookup: done, clean");
      end else begin
         $display("tb_timezone_transition_lookup: done, errors");
      end
      $finish;
   end

endmodule
